// File: design/ufds_pkg.sv
// ----------------------------------------------------------------------------
// ufds_pkg
// shared widths, codes, state type and control structs of the disjoint-set engine
// ----------------------------------------------------------------------------
package ufds_pkg;

  // fixed field widths of the request and result items and of the element count register
  localparam int ELEM_W = 10;
  localparam int SIZE_W = 11;
  localparam int CFG_W  = 11;

  // table depth default and reset value of the element count register
  localparam int               MAX_ELEMENTS_DEF   = 1024;
  localparam logic [CFG_W-1:0] NUM_ELEMENTS_RESET = 11'd1024;

  // request codes
  localparam logic ACT_FIND    = 1'b0;
  localparam logic ACT_CONNECT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMP,
    ST_LINK_BIG,
    ST_LINK_SMALL,
    ST_DONE
  } ufds_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic walk_step;
    logic begin_comp;
    logic comp_step;
    logic begin_b;
    logic link_big;
    logic link_small;
    logic publish;
  } ufds_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic req_err;
    logic node_root;
    logic action_link;
    logic phase_b;
    logic same_root;
    logic out_free;
  } ufds_stat_t;

endpackage

// File: design/ufds_if.sv
// ----------------------------------------------------------------------------
// ufds_in_if / ufds_out_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface ufds_in_if;
  import ufds_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ELEM_W-1:0] elem_a;
  logic [ELEM_W-1:0] elem_b;

  modport source (output valid, output action, output elem_a, output elem_b, input ready);
  modport sink   (input valid, input action, input elem_a, input elem_b, output ready);
endinterface

interface ufds_out_if;
  import ufds_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] root_index;
  logic [SIZE_W-1:0] set_size;
  logic              merged;
  logic              index_error;

  modport source (output valid, output root_index, output set_size, output merged,
                  output index_error, input ready);
  modport sink   (input valid, input root_index, input set_size, input merged,
                  input index_error, output ready);
endinterface

// File: design/ufds_ram.sv
// ----------------------------------------------------------------------------
// ufds_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ufds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ufds_ctrl.sv
// ----------------------------------------------------------------------------
// ufds_ctrl
// sequencer: clear sweep, root walk, path rewrite, link and result hand-off
// ----------------------------------------------------------------------------
module ufds_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ufds_pkg::ufds_stat_t  stat,
  output ufds_pkg::ufds_cmd_t   cmd
);
  import ufds_pkg::*;

  ufds_state_t state_r;
  ufds_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = stat.req_err ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (stat.node_root) state_nxt = ST_COMP;
      end
      ST_COMP: begin
        if (stat.node_root) begin
          if (stat.action_link && !stat.phase_b) begin
            state_nxt = ST_WALK;
          end else if (stat.action_link && !stat.same_root) begin
            state_nxt = ST_LINK_BIG;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LINK_BIG:   state_nxt = ST_LINK_SMALL;
      ST_LINK_SMALL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_WALK: begin
        cmd.walk_step  = !stat.node_root;
        cmd.begin_comp = stat.node_root;
      end
      ST_COMP: begin
        cmd.comp_step = !stat.node_root;
        cmd.begin_b   = stat.node_root && stat.action_link && !stat.phase_b;
      end
      ST_LINK_BIG:   cmd.link_big   = 1'b1;
      ST_LINK_SMALL: cmd.link_small = 1'b1;
      ST_DONE:       cmd.publish    = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/ufds_dp.sv
// ----------------------------------------------------------------------------
// ufds_dp
// parent table, walk pointers, captured roots and sizes, result register
// ----------------------------------------------------------------------------
module ufds_dp #(
  parameter int MAX_ELEMENTS = ufds_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [ufds_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_action,
  input  logic [ufds_pkg::ELEM_W-1:0]  in_elem_a,
  input  logic [ufds_pkg::ELEM_W-1:0]  in_elem_b,
  input  ufds_pkg::ufds_cmd_t          cmd,
  output ufds_pkg::ufds_stat_t         stat,
  ufds_out_if.source                   out_ch
);
  import ufds_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int VW = $clog2(MAX_ELEMENTS + 1);
  localparam int DW = VW + 1;

  localparam logic [AW-1:0] LAST_ADDR  = AW'(MAX_ELEMENTS - 1);
  localparam logic [31:0]   MAX_U      = 32'(MAX_ELEMENTS);
  localparam logic [DW-1:0] ENTRY_INIT = {1'b1, VW'(1)};

  logic [CFG_W-1:0] num_r;
  logic [AW-1:0]    clr_cnt_r;

  logic             act_r;
  logic             phase_b_r;
  logic             err_r;
  logic             merged_r;
  logic [AW-1:0]    b_r;
  logic [AW-1:0]    cur_r;
  logic [AW-1:0]    start_r;
  logic [AW-1:0]    top_r;
  logic [VW-1:0]    size_r;
  logic [AW-1:0]    ra_r;
  logic [VW-1:0]    sa_r;
  logic [AW-1:0]    small_r;

  logic              out_valid_r;
  logic [ELEM_W-1:0] out_root_r;
  logic [SIZE_W-1:0] out_size_r;
  logic              out_merged_r;
  logic              out_err_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic          node_root;
  logic [AW-1:0] parent;
  logic [VW-1:0] node_val;
  logic [AW-1:0] in_a_idx;
  logic [AW-1:0] in_b_idx;
  logic          a_ok;
  logic          b_ok;
  logic [VW-1:0] sum;
  logic          b_wins;
  logic [AW-1:0] big;
  logic [AW-1:0] small_idx;

  ufds_ram #(.WIDTH(DW), .DEPTH(MAX_ELEMENTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign node_root = ram_rdata[VW];
  assign node_val  = ram_rdata[VW-1:0];
  assign parent    = node_val[AW-1:0];

  assign in_a_idx = AW'(in_elem_a);
  assign in_b_idx = AW'(in_elem_b);

  // an index must be below the register value and below the table depth
  assign a_ok = ({1'b0, in_elem_a} < num_r) && (32'(in_elem_a) < MAX_U);
  assign b_ok = ({1'b0, in_elem_b} < num_r) && (32'(in_elem_b) < MAX_U);

  // the first root wins unless its set is strictly smaller
  assign sum       = sa_r + size_r;
  assign b_wins    = sa_r < size_r;
  assign big       = b_wins ? top_r : ra_r;
  assign small_idx = b_wins ? ra_r  : top_r;

  always_comb begin
    stat.clear_last  = clr_cnt_r == LAST_ADDR;
    stat.req_err     = !a_ok || ((in_action == ACT_CONNECT) && !b_ok);
    stat.node_root   = node_root;
    stat.action_link = act_r == ACT_CONNECT;
    stat.phase_b     = phase_b_r;
    stat.same_root   = ra_r == top_r;
    stat.out_free    = !out_valid_r || out_ch.ready;
  end

  // table port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = {1'b0, VW'(top_r)};
    ram_raddr = cur_r;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = ENTRY_INIT;
    end else if (cmd.accept) begin
      ram_raddr = in_a_idx;
    end else if (cmd.walk_step) begin
      ram_raddr = parent;
    end else if (cmd.begin_comp) begin
      ram_raddr = start_r;
    end else if (cmd.comp_step) begin
      ram_we    = 1'b1;
      ram_raddr = parent;
    end else if (cmd.begin_b) begin
      ram_raddr = b_r;
    end else if (cmd.link_big) begin
      ram_we    = 1'b1;
      ram_waddr = big;
      ram_wdata = {1'b1, sum};
    end else if (cmd.link_small) begin
      ram_we    = 1'b1;
      ram_waddr = small_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= NUM_ELEMENTS_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) num_r <= cfg_wr_data;
      if (cmd.clear_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk and link registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r     <= in_action;
      err_r     <= stat.req_err;
      merged_r  <= 1'b0;
      phase_b_r <= 1'b0;
      b_r       <= in_b_idx;
      cur_r     <= in_a_idx;
      start_r   <= in_a_idx;
    end
    if (cmd.walk_step || cmd.comp_step) begin
      cur_r <= parent;
    end
    if (cmd.begin_comp) begin
      top_r  <= cur_r;
      size_r <= node_val;
      cur_r  <= start_r;
    end
    if (cmd.begin_b) begin
      ra_r      <= top_r;
      sa_r      <= size_r;
      phase_b_r <= 1'b1;
      cur_r     <= b_r;
      start_r   <= b_r;
    end
    if (cmd.link_big) begin
      top_r    <= big;
      size_r   <= sum;
      small_r  <= small_idx;
      merged_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_root_r   <= err_r ? '0 : ELEM_W'(top_r);
      out_size_r   <= err_r ? '0 : SIZE_W'(size_r);
      out_merged_r <= merged_r && !err_r;
      out_err_r    <= err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.root_index  = out_root_r;
  assign out_ch.set_size    = out_size_r;
  assign out_ch.merged      = out_merged_r;
  assign out_ch.index_error = out_err_r;

endmodule

// File: design/union_find_disjoint_sets.sv
// ----------------------------------------------------------------------------
// union_find_disjoint_sets
// disjoint-set engine with union by size and full path compression
// ----------------------------------------------------------------------------
// find: walk from elem_a to its root, then rewrite every node on the path to point at the root
// connect: walk and rewrite a, then b; the two link writes follow only when the roots differ
// out-of-range request: no walk, straight to the result; the next item is taken the cycle after the result is loaded
// each hop is a read of the parent table ram, which has a single read port
// after reset the table is swept to all singletons, MAX_ELEMENTS entries (1024 by default),
// during which no item is taken; cfg writes are accepted at any time
module union_find_disjoint_sets #(
  parameter int MAX_ELEMENTS = ufds_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [ufds_pkg::CFG_W-1:0] cfg_wr_data,
  ufds_in_if.sink                    in_ch,
  ufds_out_if.source                 out_ch
);
  import ufds_pkg::*;

  // command and status buses between sequencer and datapath
  ufds_cmd_t  cmd;
  ufds_stat_t stat;
  logic       in_ready;

  // sequencer: owns the input handshake and steps each item through
  // walk a, rewrite a and, for a connect, walk b, rewrite b, then the two link writes if the roots differ
  ufds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath: parent table, element count register and result register;
  // the result register lets a new item start while a finished one waits
  ufds_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_action   (in_ch.action),
    .in_elem_a   (in_ch.elem_a),
    .in_elem_b   (in_ch.elem_b),
    .cmd         (cmd),
    .stat        (stat),
    .out_ch      (out_ch)
  );

  // at most one table write source per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_step, cmd.comp_step, cmd.link_big, cmd.link_small}))
    else $error("more than one table write in a cycle");

  // no item is taken while the table is being swept
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !in_ch.ready)
    else $error("input ready during table sweep");

  // a result is only loaded when the previous one is gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten before taken");

  // a rejected request reports zero root, size and merge
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.index_error) |->
      (out_ch.root_index == '0 && out_ch.set_size == '0 && !out_ch.merged))
    else $error("error result carries nonzero fields");

  // the link writes always follow each other
  a_link_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.link_big |=> cmd.link_small)
    else $error("link sequence broken");

endmodule
